/* sv/bfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types, constants and helpers of the black frame run detector.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int PIXEL_COUNT_BITS = 24;

    localparam int FRACTION_BITS = 17;
    localparam int LEVEL_BITS    = 9;
    localparam int CFG_DATA_BITS = 17;
    localparam int RUN_BITS      = 16;
    localparam int DARK_OUT_BITS = 24;
    localparam int FRAC_SHIFT    = 16;

    localparam int PROD_BITS     = PIXEL_COUNT_BITS + FRACTION_BITS;
    localparam int DARK_EXT_BITS = (PIXEL_COUNT_BITS > DARK_OUT_BITS) ?
                                   PIXEL_COUNT_BITS : DARK_OUT_BITS;

    localparam logic [7:0] LUMA_R     = 8'd77;
    localparam logic [7:0] LUMA_G     = 8'd150;
    localparam logic [7:0] LUMA_B     = 8'd29;
    localparam int         LUMA_SHIFT = 8;

    localparam logic [FRACTION_BITS-1:0] FRACTION_RESET = 17'd62259;
    localparam logic [LEVEL_BITS-1:0]    LEVEL_RESET    = 9'd16;
    localparam logic [RUN_BITS-1:0]      RUN_MAX        = '1;
    localparam logic [DARK_OUT_BITS-1:0] DARK_OUT_MAX   = '1;

    typedef enum logic [1:0] {
        MODE_PIXEL = 2'd0,
        MODE_SKIP  = 2'd1,
        MODE_FAIL  = 2'd2
    } mode_t;

    typedef enum logic [0:0] {
        CFG_DARK_FRACTION = 1'b0,
        CFG_DARK_LEVEL    = 1'b1
    } cfg_index_t;

    typedef logic [PIXEL_COUNT_BITS-1:0] count_t;

    // one request from the input register
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    // frame event handed to the decision stages
    typedef struct packed {
        logic   clr;
        count_t dark;
        count_t total;
    } frame_evt_t;

    function automatic logic [DARK_OUT_BITS-1:0] dark_sat(input count_t d);
        logic [DARK_EXT_BITS-1:0] ext;
        ext = DARK_EXT_BITS'(d);
        return (ext > DARK_EXT_BITS'(DARK_OUT_MAX)) ? DARK_OUT_MAX
                                                    : ext[DARK_OUT_BITS-1:0];
    endfunction

endpackage

/* sv/bfr_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_in_if
// Pixel request channel: valid/ready with mode, color and frame marker.
// ----------------------------------------------------------------------------
interface bfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (output valid, mode, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, mode, red, green, blue, last_pixel, output ready);
endinterface

/* sv/bfr_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_out_if
// Frame result channel: valid/ready with black flag, run and dark count.
// ----------------------------------------------------------------------------
interface bfr_out_if;
    logic        valid;
    logic        ready;
    logic        is_black;
    logic [15:0] run_count;
    logic [23:0] dark_pixels;

    modport source (output valid, is_black, run_count, dark_pixels, input ready);
    modport sink   (input valid, is_black, run_count, dark_pixels, output ready);
endinterface

/* sv/black_frame_run_detector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// black_frame_run_detector_top
// Counts dark pixels per frame, classifies black frames, tracks the run.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          mode, red, green, blue, last_pixel
//  out_ch    out  valid/ready          is_black, run_count, dark_pixels
//  cfg       in   cfg_we               cfg_index, cfg_data
//
//  one request per cycle unless out_ch stalls; a frame result passes the
//  input, event, product and output regs after the request ending a frame
//  the 17x24 fraction multiply sits alone in its own stage
//  stalls on out_ch back up through the stages; ready is a simple chain
//  reset clears counters, run, valids and loads the default registers
// ----------------------------------------------------------------------------
module black_frame_run_detector_top
    import bfr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    bfr_in_if.sink                   in_ch,
    bfr_out_if.source                out_ch
);

    logic [FRACTION_BITS-1:0] frac_reg,  frac_next;
    logic [LEVEL_BITS-1:0]    level_reg, level_next;

    logic       s1_v_reg, s1_v_next;
    pixel_t     s1_reg;
    logic       s2_v_reg, s2_v_next;
    frame_evt_t s2_reg;
    logic       s3_v_reg, s3_v_next;
    logic       s3_clr_reg;
    count_t     s3_dark_reg;
    logic [PROD_BITS-1:0] s3_prod_reg;

    logic                     out_v_reg, out_v_next;
    logic                     out_black_reg;
    logic [RUN_BITS-1:0]      run_reg, run_next;
    logic [DARK_OUT_BITS-1:0] out_dark_reg;

    logic       out_free, s3_ready, s2_ready, s1_ready;
    logic       s3_adv, s2_adv, s1_adv, in_acc;
    logic       evt_valid;
    frame_evt_t evt;
    logic       black;
    logic [PROD_BITS-1:0] dark_scaled;

    // configuration decode
    always_comb
    begin
        frac_next  = frac_reg;
        level_next = level_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DARK_FRACTION: frac_next  = cfg_data[FRACTION_BITS-1:0];
                CFG_DARK_LEVEL:    level_next = cfg_data[LEVEL_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // ready chain
    always_comb
    begin
        out_free = !out_v_reg || out_ch.ready;
        s3_ready = !s3_v_reg || out_free;
        s2_ready = !s2_v_reg || s3_ready;
        s1_ready = !s1_v_reg || s2_ready;
        s3_adv   = s3_v_reg && out_free;
        s2_adv   = s2_v_reg && s3_ready;
        s1_adv   = s1_v_reg && s2_ready;
        in_acc   = in_ch.valid && s1_ready;
    end

    assign in_ch.ready = s1_ready;

    bfr_count u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (s1_adv),
        .pix        (s1_reg),
        .dark_level (level_reg),
        .evt_valid  (evt_valid),
        .evt        (evt)
    );

    // black when not cleared and dark * 2^16 >= fraction * total
    always_comb
    begin
        dark_scaled = PROD_BITS'(s3_dark_reg) << FRAC_SHIFT;
        black       = !s3_clr_reg && (dark_scaled >= s3_prod_reg);
        run_next    = run_reg;
        if (s3_adv)
        begin
            if (black)
                run_next = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
            else
                run_next = '0;
        end
    end

    always_comb
    begin
        s1_v_next  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_reg);
        s2_v_next  = evt_valid ? 1'b1 : (s2_adv ? 1'b0 : s2_v_reg);
        s3_v_next  = s2_adv ? 1'b1 : (s3_adv ? 1'b0 : s3_v_reg);
        out_v_next = s3_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg  <= FRACTION_RESET;
            level_reg <= LEVEL_RESET;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            run_reg   <= '0;
        end
        else
        begin
            frac_reg  <= frac_next;
            level_reg <= level_next;
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            s3_v_reg  <= s3_v_next;
            out_v_reg <= out_v_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg.mode       <= in_ch.mode;
            s1_reg.red        <= in_ch.red;
            s1_reg.green      <= in_ch.green;
            s1_reg.blue       <= in_ch.blue;
            s1_reg.last_pixel <= in_ch.last_pixel;
        end
        if (evt_valid)
            s2_reg <= evt;
        if (s2_adv)
        begin
            s3_clr_reg  <= s2_reg.clr;
            s3_dark_reg <= s2_reg.dark;
            s3_prod_reg <= PROD_BITS'(frac_reg) * PROD_BITS'(s2_reg.total);
        end
        if (s3_adv)
        begin
            out_black_reg <= black;
            out_dark_reg  <= dark_sat(s3_dark_reg);
        end
    end

    assign out_ch.valid       = out_v_reg;
    assign out_ch.is_black    = out_black_reg;
    assign out_ch.run_count   = run_reg;
    assign out_ch.dark_pixels = out_dark_reg;

    a_clear_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_black_reg) |-> (run_reg == '0))
        else $error("run not cleared on a frame that is not black");

    a_black_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_black_reg) |-> (run_reg != '0))
        else $error("black frame with empty run");

    a_clear_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_adv && s3_clr_reg) |=> (out_dark_reg == '0 && !out_black_reg))
        else $error("skip or failure reported dark pixels");

endmodule

/* sv/bfr_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_count
// Luma and dark test of one pixel, saturating frame counters, frame events.
// ----------------------------------------------------------------------------
module bfr_count
    import bfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  pixel_t                pix,
    input  logic [LEVEL_BITS-1:0] dark_level,
    output logic                  evt_valid,
    output frame_evt_t            evt
);

    count_t      dark_cnt_reg,  dark_cnt_next;
    count_t      pix_cnt_reg,   pix_cnt_next;
    logic [15:0] luma_sum;
    logic [7:0]  luma;
    logic        is_dark;
    logic        is_pixel;
    count_t      dark_inc;
    count_t      pix_inc;

    always_comb
    begin
        luma_sum = (16'(LUMA_R) * 16'(pix.red)) + (16'(LUMA_G) * 16'(pix.green))
                 + (16'(LUMA_B) * 16'(pix.blue));
        luma     = luma_sum[LUMA_SHIFT +: 8];
        is_dark  = {1'b0, luma} < dark_level;
        is_pixel = pix.mode == MODE_PIXEL;
        pix_inc  = (pix_cnt_reg == '1) ? pix_cnt_reg : pix_cnt_reg + 1'b1;
        dark_inc = !is_dark ? dark_cnt_reg
                 : (dark_cnt_reg == '1) ? dark_cnt_reg : dark_cnt_reg + 1'b1;
    end

    always_comb
    begin
        evt.clr   = !is_pixel;
        evt.dark  = is_pixel ? dark_inc : '0;
        evt.total = is_pixel ? pix_inc  : '0;
        evt_valid = adv && (!is_pixel || pix.last_pixel);

        dark_cnt_next = dark_cnt_reg;
        pix_cnt_next  = pix_cnt_reg;
        if (adv)
        begin
            if (!is_pixel || pix.last_pixel)
            begin
                dark_cnt_next = '0;
                pix_cnt_next  = '0;
            end
            else
            begin
                dark_cnt_next = dark_inc;
                pix_cnt_next  = pix_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_cnt_reg <= '0;
            pix_cnt_reg  <= '0;
        end
        else
        begin
            dark_cnt_reg <= dark_cnt_next;
            pix_cnt_reg  <= pix_cnt_next;
        end
    end

    // a dark pixel is always also a counted pixel
    a_dark_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        dark_cnt_reg <= pix_cnt_reg)
        else $error("dark count above pixel count");

    a_event_resets: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |=> (dark_cnt_reg == '0 && pix_cnt_reg == '0))
        else $error("counters not cleared after frame event");

endmodule

/* tb/black_frame_run_detector_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// black_frame_run_detector_top_tb
// Self-checking bench for the black frame run detector. Pixel frames, skips
// and failed grabs go in over a valid/ready channel with random gaps. A
// scoreboard predicts each frame verdict from its own luma and counter model
// and compares every field of each result in order. The thresholds are
// reprogrammed between phases, and a burst of single pixel frames runs with
// no gaps at all.
// ----------------------------------------------------------------------------
module black_frame_run_detector_top_tb
    import bfr_pkg::*;
();

    localparam logic [1:0] MODE_UNUSED        = 2'd3;
    localparam logic [FRACTION_BITS-1:0] DEFAULT_FRACTION = 17'd62259;
    localparam logic [LEVEL_BITS-1:0]    DEFAULT_LEVEL    = 9'd16;
    localparam int SETTLE_CYCLES   = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_PERCENT    = 38;

    // predicts frame verdicts and checks them in arrival order
    class black_run_scoreboard;
        typedef struct {
            logic                     is_black;
            logic [RUN_BITS-1:0]      run_count;
            logic [DARK_OUT_BITS-1:0] dark_pixels;
        } verdict_t;

        logic [FRACTION_BITS-1:0] fraction;
        logic [LEVEL_BITS-1:0]    level;
        count_t                   dark_cnt;
        count_t                   pixel_cnt;
        logic [RUN_BITS-1:0]      run;
        verdict_t                 pending_verdicts[$];
        int                       errors;

        function new();
            fraction  = DEFAULT_FRACTION;
            level     = DEFAULT_LEVEL;
            dark_cnt  = '0;
            pixel_cnt = '0;
            run       = '0;
            errors    = 0;
        endfunction

        function void write_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_DARK_FRACTION: fraction = data[FRACTION_BITS-1:0];
                CFG_DARK_LEVEL:    level    = data[LEVEL_BITS-1:0];
                default:           ;
            endcase
        endfunction

        function void note_request(pixel_t req);
            int unsigned     luma;
            longint unsigned dark_scaled;
            longint unsigned needed;
            verdict_t        v;
            if (req.mode != MODE_PIXEL)
            begin
                // skip, failed grab and the unused code all drop the frame
                run       = '0;
                dark_cnt  = '0;
                pixel_cnt = '0;
                v.is_black    = 1'b0;
                v.run_count   = '0;
                v.dark_pixels = '0;
                pending_verdicts.push_back(v);
                return;
            end
            luma = (32'd77 * req.red + 32'd150 * req.green + 32'd29 * req.blue) >> 8;
            if (pixel_cnt != '1)
                pixel_cnt = pixel_cnt + 1'b1;
            if (luma < level && dark_cnt != '1)
                dark_cnt = dark_cnt + 1'b1;
            if (!req.last_pixel)
                return;
            dark_scaled = dark_cnt;
            dark_scaled = dark_scaled << 16;
            needed      = fraction;
            needed      = needed * pixel_cnt;
            v.is_black  = (dark_scaled >= needed);
            if (!v.is_black)
                run = '0;
            else if (run != '1)
                run = run + 1'b1;
            v.run_count   = run;
            v.dark_pixels = dark_cnt;
            pending_verdicts.push_back(v);
            dark_cnt  = '0;
            pixel_cnt = '0;
        endfunction

        function void check_result(logic is_black, logic [RUN_BITS-1:0] run_count,
                                   logic [DARK_OUT_BITS-1:0] dark_pixels);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result is_black=%0d run_count=%0d dark_pixels=%0d",
                         $time, is_black, run_count, dark_pixels);
                errors++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (is_black !== v.is_black)
            begin
                $display("%0t: is_black expected %0d actual %0d", $time, v.is_black, is_black);
                errors++;
            end
            if (run_count !== v.run_count)
            begin
                $display("%0t: run_count expected %0d actual %0d",
                         $time, v.run_count, run_count);
                errors++;
            end
            if (dark_pixels !== v.dark_pixels)
            begin
                $display("%0t: dark_pixels expected %0d actual %0d",
                         $time, v.dark_pixels, dark_pixels);
                errors++;
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [0:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    bfr_in_if  pix_ch();
    bfr_out_if verdict_ch();

    black_frame_run_detector_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (pix_ch),
        .out_ch    (verdict_ch)
    );

    black_run_scoreboard verdicts;
    bit idle_on;
    bit hold_armed;
    int sent_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        verdict_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                verdict_ch.ready <= 1'b0;
            end
            else
            begin
                verdict_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
            verdicts.check_result(verdict_ch.is_black, verdict_ch.run_count,
                                  verdict_ch.dark_pixels);
    end

    task automatic offer_request(input logic [1:0] mode, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b,
                                 input logic last);
        pixel_t req;
        req.mode       = mode;
        req.red        = r;
        req.green      = g;
        req.blue       = b;
        req.last_pixel = last;
        while (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.mode       <= mode;
        pix_ch.red        <= r;
        pix_ch.green      <= g;
        pix_ch.blue       <= b;
        pix_ch.last_pixel <= last;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        verdicts.note_request(req);
        sent_count++;
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        verdicts.write_register(idx, data);
    endtask

    // let every result come back, then let trailing pixels leave the pipe
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (verdicts.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // component small enough that any mix of three stays below a nonzero level
    function automatic logic [7:0] dark_component();
        int cap;
        if (verdicts.level == 0 || verdicts.level > 256)
            cap = 255;
        else
            cap = verdicts.level - 1;
        return 8'($urandom_range(cap, 0));
    endfunction

    task automatic send_random_frame(input int max_len);
        int         len;
        int         dark_pct;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        len = $urandom_range(max_len, 1);
        case ($urandom_range(5))
            0, 1:    dark_pct = 100;
            2:       dark_pct = 96;
            3:       dark_pct = 90;
            4:       dark_pct = 50;
            default: dark_pct = 0;
        endcase
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 3)
            begin
                // abort in mid frame
                offer_request(2'($urandom_range(3, 1)), 8'($urandom), 8'($urandom),
                              8'($urandom), 1'($urandom));
                return;
            end
            if ($urandom_range(99) < dark_pct)
            begin
                r = dark_component();
                g = dark_component();
                b = dark_component();
            end
            else
            begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
            end
            offer_request(MODE_PIXEL, r, g, b, i == len - 1);
        end
    endtask

    task automatic random_phase(input int budget, input int max_len);
        int start;
        start = sent_count;
        while (sent_count - start < budget)
        begin
            if ($urandom_range(99) < 6)
                offer_request(2'($urandom_range(3, 1)), 8'($urandom), 8'($urandom),
                              8'($urandom), 1'($urandom));
            else
                send_random_frame(max_len);
        end
    endtask

    initial
    begin
        verdicts   = new();
        idle_on    = 1'b1;
        hold_armed = 1'b0;
        sent_count = 0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_DARK_FRACTION;
        cfg_data          <= '0;
        pix_ch.valid      <= 1'b0;
        pix_ch.mode       <= MODE_PIXEL;
        pix_ch.red        <= '0;
        pix_ch.green      <= '0;
        pix_ch.blue       <= '0;
        pix_ch.last_pixel <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default thresholds straight out of reset
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
        offer_request(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1);
        offer_request(MODE_PIXEL, 8'd15, 8'd15, 8'd15, 1'b0);
        offer_request(MODE_PIXEL, 8'd15, 8'd15, 8'd15, 1'b1);
        offer_request(MODE_PIXEL, 8'd16, 8'd16, 8'd16, 1'b1);   // luma equal to level
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
        offer_request(MODE_SKIP, 8'd0, 8'd0, 8'd0, 1'b0);
        // failed grab must drop the bright pixel already counted
        offer_request(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0);
        offer_request(MODE_FAIL, 8'd0, 8'd0, 8'd0, 1'b1);
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
        offer_request(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0);
        offer_request(MODE_UNUSED, 8'd255, 8'd255, 8'd255, 1'b0);
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
        offer_request(MODE_PIXEL, 8'd255, 8'd0, 8'd0, 1'b1);
        offer_request(MODE_PIXEL, 8'd0, 8'd255, 8'd0, 1'b1);
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd255, 1'b1);
        random_phase(110, 12);
        settle();

        // half the pixels dark sits exactly on the threshold
        write_register(CFG_DARK_FRACTION, 17'd32768);
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0);
        offer_request(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1);
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0);
        offer_request(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0);
        offer_request(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1);
        random_phase(100, 12);
        settle();

        // nothing dark, zero fraction: every frame still black
        write_register(CFG_DARK_LEVEL, 9'd0);
        write_register(CFG_DARK_FRACTION, 17'd0);
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
        hold_armed = 1'b1;
        random_phase(80, 2);
        settle();

        // everything dark, full fraction
        write_register(CFG_DARK_FRACTION, 17'd65536);
        write_register(CFG_DARK_LEVEL, 9'd256);
        offer_request(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1);
        random_phase(90, 12);
        settle();

        // fraction above one: no frame can be black
        write_register(CFG_DARK_FRACTION, 17'h1FFFF);
        write_register(CFG_DARK_LEVEL, 9'h1FF);
        offer_request(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
        random_phase(70, 12);
        settle();

        repeat (3)
        begin
            if ($urandom_range(3) == 0)
                write_register(CFG_DARK_FRACTION, 17'($urandom));
            else
                write_register(CFG_DARK_FRACTION, 17'($urandom_range(65536, 30000)));
            write_register(CFG_DARK_LEVEL, 9'($urandom_range(300, 1)));
            random_phase(60, 12);
            settle();
        end

        // back to back single pixel frames, no gaps, run keeps growing
        idle_on = 1'b0;
        write_register(CFG_DARK_FRACTION, 17'd0);
        repeat (40)
            offer_request(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        offer_request(MODE_SKIP, 8'd0, 8'd0, 8'd0, 1'b0);
        settle();
        idle_on = 1'b1;

        write_register(CFG_DARK_FRACTION, DEFAULT_FRACTION);
        write_register(CFG_DARK_LEVEL, 9'd40);
        random_phase(60, 12);

        settle();
        repeat (10) @(posedge clk);
        if (verdicts.errors == 0)
            $display("black_frame_run_detector_top_tb: PASS");
        else
            $display("black_frame_run_detector_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("black_frame_run_detector_top_tb: FAIL");
        $finish;
    end

endmodule
